// ===== sv/triclinic_cell_list_binner_macros.svh =====
// ----------------------------------------------------------------------------
// Triclinic cell list binner assertion macros
// Concurrent assertion wrappers clocked on clk_i with the active-low reset.
// ----------------------------------------------------------------------------
`ifndef TRICLINIC_CELL_LIST_BINNER_MACROS_SVH
`define TRICLINIC_CELL_LIST_BINNER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TCLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define TCLB_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

// ===== sv/tclb_pkg.sv =====
// ----------------------------------------------------------------------------
// Triclinic cell list binner package
// Shared widths, codes and constants of the binner and its head table RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tclb_pkg;

  localparam int unsigned MaxCells   = 4096;
  localparam int unsigned CellAddrW  = $clog2(MaxCells);
  localparam int unsigned PartW      = 16;
  localparam int unsigned HeadW      = PartW + 1;
  localparam int unsigned CoefW      = 32;
  localparam int unsigned PosW       = 32;
  localparam int unsigned GridW      = 24;
  localparam int unsigned CountW     = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned InDataW    = 128;
  localparam int unsigned OutDataW   = 32;
  localparam int unsigned ProdW      = 64;
  localparam int unsigned AccW       = 66;
  localparam int unsigned ScaledW    = 75;
  localparam int unsigned FracBits   = 40;
  localparam int unsigned FloorW     = ScaledW - FracBits;
  localparam int unsigned BitCntW    = 6;

  localparam logic [GridW-1:0] GridReset = 24'h010101;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_BIN   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INV_XX = 3'd0,
    REG_INV_YY = 3'd1,
    REG_INV_ZZ = 3'd2,
    REG_INV_YZ = 3'd3,
    REG_INV_XZ = 3'd4,
    REG_INV_XY = 3'd5,
    REG_GRID   = 3'd6,
    REG_SPARE  = 3'd7
  } reg_e;

endpackage

// ===== sv/tclb_ram.sv =====
// ----------------------------------------------------------------------------
// Triclinic cell list binner RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tclb_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word and register one read word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/triclinic_cell_list_binner.sv =====
// ----------------------------------------------------------------------------
// Triclinic cell list binner
// Bins particles into cells of a periodic triclinic box and keeps a linked
// cell list in a head table RAM, using a shared multiplier for the coordinate and
// index products, a scale multiplier and a bit-serial remainder step under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Registers are written on the cfg channel (index, data); cfg_ready_o is
//   always high. Write them only while the block is idle.
//   Commands enter on s_axis: tuser holds the command, tdata the particle
//   index, position and query cell. Each command gives one transfer on
//   m_axis: tdata holds cell index and link particle, tuser the link valid.
//   A bin runs six multiply-accumulate pairs in all, and per axis a scale
//   step, a sign step and the bit-serial remainder loop over the 35 floor
//   bits, then the index multiplies and the head table read and write; a
//   read only reads the head table; a clear writes every head table entry,
//   one per cycle.
//   s_axis_tready is high only while the sequencer waits for a command.
//   After reset the block sweeps every head table entry empty and accepts
//   no command meanwhile; the sweep gives no result.
//   A finished result sits in the output register; if the receiver stalls,
//   the next command is still taken and its result waits until the held
//   one is transferred.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triclinic_cell_list_binner_macros.svh"

module triclinic_cell_list_binner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tclb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  // command stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: particle_index[15:0], pos_x[47:16], pos_y[79:48], pos_z[111:80],
  //        query_cell[123:112], zero[127:124]
  input  logic [tclb_pkg::InDataW-1:0] s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]                   s_axis_tuser,
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: cell_index[11:0], link_particle[27:12], zero[31:28]
  output logic [tclb_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: link_valid[0]
  output logic                         m_axis_tuser
);

  import tclb_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_CLEAR = 12'b0000_0000_0010,
    ST_MUL   = 12'b0000_0000_0100,
    ST_ACC   = 12'b0000_0000_1000,
    ST_SCALE = 12'b0000_0001_0000,
    ST_SIGN  = 12'b0000_0010_0000,
    ST_DIV   = 12'b0000_0100_0000,
    ST_LMUL  = 12'b0000_1000_0000,
    ST_LADD  = 12'b0001_0000_0000,
    ST_RD    = 12'b0010_0000_0000,
    ST_WR    = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_e;

  localparam logic signed [AccW-1:0] HalfQ40 = AccW'(1) <<< (FracBits - 1);

  // configuration registers
  logic signed [CoefW-1:0] inv_xx_q, inv_yy_q, inv_zz_q, inv_yz_q, inv_xz_q, inv_xy_q;
  logic [GridW-1:0]        grid_q;

  // sequencer and datapath registers
  state_e                  state_q, state_d;
  logic [2:0]              step_q;
  logic [1:0]              axis_q;
  logic                    lin_step_q;
  logic                    is_bin_q;
  logic                    clr_out_q;
  logic [CellAddrW-1:0]    clr_cnt_q;
  logic [PartW-1:0]        pidx_q;
  logic signed [PosW-1:0]  pos_x_q, pos_y_q, pos_z_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [ScaledW-1:0] scaled_q;
  logic [FloorW-1:0]       mag_q;
  logic                    neg_q;
  logic [CountW-1:0]       rem_q;
  logic [BitCntW-1:0]      bit_cnt_q;
  logic [CountW-1:0]       coord_q [3];
  logic [CellAddrW-1:0]    lin_q;
  logic [CellAddrW-1:0]    cell_q;
  logic [HeadW-1:0]        link_q;

  // output register
  logic                    out_valid_q;
  logic [CellAddrW-1:0]    out_cell_q;
  logic                    out_lvalid_q;
  logic [PartW-1:0]        out_part_q;

  // combinational nets
  logic [CountW-1:0]       nx, ny, nz, n_cur;
  logic signed [CoefW-1:0] mul_a;
  logic signed [PosW-1:0]  mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [ScaledW-1:0] scaled_d;
  logic [FloorW-1:0]       floor_v;
  logic [CountW:0]         rem_try;
  logic [CountW:0]         rem_sub;
  logic [CountW-1:0]       rem_new;
  logic [CountW-1:0]       coord_new;
  logic                    ram_we, ram_re;
  logic [CellAddrW-1:0]    ram_waddr;
  logic [HeadW-1:0]        ram_wdata, ram_rdata;
  logic                    in_xfer, out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Decode axis counts, a zero count acts as one
  assign nx = (grid_q[7:0]   == '0) ? CountW'(1) : grid_q[7:0];
  assign ny = (grid_q[15:8]  == '0) ? CountW'(1) : grid_q[15:8];
  assign nz = (grid_q[23:16] == '0) ? CountW'(1) : grid_q[23:16];

  always_comb begin
    unique case (axis_q)
      2'd0:    n_cur = nx;
      2'd1:    n_cur = ny;
      default: n_cur = nz;
    endcase
  end

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_LMUL) begin
      mul_a = lin_step_q ? CoefW'(lin_q) : CoefW'(coord_q[2]);
      mul_b = lin_step_q ? PosW'(nx) : PosW'(ny);
    end else begin
      case (step_q)
        3'd0: begin mul_a = inv_xx_q; mul_b = pos_x_q; end
        3'd1: begin mul_a = inv_xy_q; mul_b = pos_y_q; end
        3'd2: begin mul_a = inv_xz_q; mul_b = pos_z_q; end
        3'd3: begin mul_a = inv_yy_q; mul_b = pos_y_q; end
        3'd4: begin mul_a = inv_yz_q; mul_b = pos_z_q; end
        default: begin mul_a = inv_zz_q; mul_b = pos_z_q; end
      endcase
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign scaled_d = acc_q * $signed({1'b0, n_cur});
  assign floor_v  = scaled_q[ScaledW-1:FracBits];

  // One restoring remainder step
  assign rem_try   = {rem_q, mag_q[bit_cnt_q]};
  assign rem_sub   = rem_try - {1'b0, n_cur};
  assign rem_new   = (rem_try >= {1'b0, n_cur}) ? rem_sub[CountW-1:0] : rem_try[CountW-1:0];
  assign coord_new = (neg_q && (rem_new != '0)) ? (n_cur - CountW'(1)) : rem_new;

  // Drive head table ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_q;
    ram_wdata = {1'b1, pidx_q};
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (state_q == ST_WR && is_bin_q) begin
      ram_we = 1'b1;
    end
  end
  assign ram_re = (state_q == ST_RD);

  tclb_ram #(
    .Width (HeadW),
    .Depth (MaxCells)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cell_q),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (s_axis_tuser)
            CMD_CLEAR: state_d = ST_CLEAR;
            CMD_BIN:   state_d = ST_MUL;
            CMD_READ:  state_d = ST_RD;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: if (clr_cnt_q == '1) state_d = clr_out_q ? ST_DONE : ST_IDLE;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC: begin
        if (step_q == 3'd2 || step_q == 3'd4 || step_q == 3'd5) state_d = ST_SCALE;
        else state_d = ST_MUL;
      end
      ST_SCALE: state_d = ST_SIGN;
      ST_SIGN:  state_d = ST_DIV;
      ST_DIV: begin
        if (bit_cnt_q == '0) state_d = (axis_q == 2'd2) ? ST_LMUL : ST_MUL;
      end
      ST_LMUL:  state_d = ST_LADD;
      ST_LADD:  state_d = lin_step_q ? ST_RD : ST_LMUL;
      ST_RD:    state_d = ST_WR;
      ST_WR:    state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_out_q   <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      axis_q      <= '0;
      lin_step_q  <= 1'b0;
      is_bin_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + CellAddrW'(1);
      if (state_q == ST_IDLE && in_xfer) begin
        clr_out_q  <= 1'b1;
        clr_cnt_q  <= '0;
        step_q     <= '0;
        axis_q     <= '0;
        lin_step_q <= 1'b0;
        is_bin_q   <= (s_axis_tuser == CMD_BIN);
      end
      if (state_q == ST_ACC && state_d == ST_MUL) step_q <= step_q + 3'd1;
      if (state_q == ST_DIV && bit_cnt_q == '0 && axis_q != 2'd2) begin
        step_q <= step_q + 3'd1;
        axis_q <= axis_q + 2'd1;
      end
      if (state_q == ST_LADD) lin_step_q <= 1'b1;
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_xx_q <= '0;
      inv_yy_q <= '0;
      inv_zz_q <= '0;
      inv_yz_q <= '0;
      inv_xz_q <= '0;
      inv_xy_q <= '0;
      grid_q   <= GridReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_INV_XX: inv_xx_q <= cfg_data_i;
        REG_INV_YY: inv_yy_q <= cfg_data_i;
        REG_INV_ZZ: inv_zz_q <= cfg_data_i;
        REG_INV_YZ: inv_yz_q <= cfg_data_i;
        REG_INV_XZ: inv_xz_q <= cfg_data_i;
        REG_INV_XY: inv_xy_q <= cfg_data_i;
        REG_GRID:   grid_q   <= cfg_data_i[GridW-1:0];
        default:    ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        pidx_q  <= s_axis_tdata[15:0];
        pos_x_q <= s_axis_tdata[47:16];
        pos_y_q <= s_axis_tdata[79:48];
        pos_z_q <= s_axis_tdata[111:80];
        cell_q  <= (s_axis_tuser == CMD_READ) ? s_axis_tdata[123:112] : '0;
        link_q  <= '0;
        acc_q   <= HalfQ40;
      end
      ST_MUL:   prod_q <= mul_p;
      ST_ACC:   acc_q <= acc_q + AccW'(prod_q);
      ST_SCALE: scaled_q <= scaled_d;
      ST_SIGN: begin
        neg_q     <= floor_v[FloorW-1];
        mag_q     <= floor_v[FloorW-1] ? (~floor_v + FloorW'(1)) : floor_v;
        rem_q     <= '0;
        bit_cnt_q <= BitCntW'(FloorW - 1);
      end
      ST_DIV: begin
        rem_q     <= rem_new;
        bit_cnt_q <= bit_cnt_q - BitCntW'(1);
        if (bit_cnt_q == '0) begin
          coord_q[axis_q] <= coord_new;
          acc_q           <= HalfQ40;
        end
      end
      ST_LMUL:  prod_q <= mul_p;
      ST_LADD: begin
        if (lin_step_q) cell_q <= prod_q[CellAddrW-1:0] + CellAddrW'(coord_q[0]);
        else lin_q <= prod_q[CellAddrW-1:0] + CellAddrW'(coord_q[1]);
      end
      ST_WR:    link_q <= ram_rdata;
      default:  ;
    endcase
    if (state_q == ST_DONE && out_free) begin
      out_cell_q   <= cell_q;
      out_lvalid_q <= link_q[HeadW-1];
      out_part_q   <= link_q[HeadW-1] ? link_q[PartW-1:0] : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_part_q, out_cell_q};
  assign m_axis_tuser  = out_lvalid_q;

  `TCLB_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE),
               "result appeared without a finished command")
  `TCLB_ASSERT(a_no_write_idle, (state_q == ST_IDLE) |-> !ram_we,
               "head table written while idle")
  `TCLB_ASSERT(a_rem_bound, (state_q == ST_DIV) |-> (rem_q < n_cur),
               "remainder out of range")
  `TCLB_ASSERT_NEXT(a_clear_runs, (state_q == ST_CLEAR && clr_cnt_q != '1),
                    (state_q == ST_CLEAR), "clear sweep ended early")

endmodule
